@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks used across the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define AST_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset
`define AST_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/apt_pkg.sv @@
// ----------------------------------------------------------------------------
// apt_pkg
// Types and constants shared by the affine point transform modules.
// ----------------------------------------------------------------------------
package apt_pkg;

   localparam int COORD_W  = 32;
   localparam int PROD_W   = 64;
   localparam int SUM_W    = 64;
   localparam int MAT_ROWS = 3;
   localparam int MAT_COLS = 4;
   localparam int IDX_W    = 2;

   // Item kinds
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_POINT = 1'b1;

   // A load to this row is dropped
   localparam logic [IDX_W-1:0] ROW_IGNORE = 2'd3;

   // Column holding the translation term
   localparam logic [IDX_W-1:0] COL_TRANS = 2'd3;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [MAT_COLS-1:0][COORD_W-1:0] mat_row_type;

   localparam coord_type COORD_MAX = 32'sh7FFF_FFFF;
   localparam coord_type COORD_MIN = 32'sh8000_0000;

   // Matrix entry write request
   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      coord_type        value;
   } mat_wr_type;

   // Stage advance enables for the row datapath
   typedef struct packed {
      logic adv1;
      logic adv2;
   } pipe_ctl_type;

endpackage

@@ rtl/affine_point_transform.sv @@
// ----------------------------------------------------------------------------
// affine_point_transform
// Streams 3D points through a 3x4 affine matrix in signed fixed point.
// A point word passes the valid registers v1_ff, v2_ff and v3_ff in turn, and
// rsp_valid is v3_ff, registered like the result word.
// Throughput: one word per cycle; three register stages (multiply, round/add,
// saturate) each take a new point every cycle while rsp_stall is low.
// Matrix loads take effect for the next word and give no result word.
// Reset clears the pipeline valid bits and loads the identity matrix.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module affine_point_transform import apt_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_mode,
   input  logic [IDX_W-1:0] req_row_index,
   input  logic [IDX_W-1:0] req_col_index,
   input  coord_type        req_entry_value,
   input  coord_type        req_in_x,
   input  coord_type        req_in_y,
   input  coord_type        req_in_z,
   input  logic             req_last_point,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output coord_type        rsp_out_x,
   output coord_type        rsp_out_y,
   output coord_type        rsp_out_z,
   output logic             rsp_out_last,
   output logic             rsp_saturated
);

   logic         v1_ff, v2_ff, v3_ff;
   logic         rdy1, rdy2, rdy3;
   logic         req_accept;
   logic         last1_ff, last2_ff, last3_ff;
   mat_wr_type   wr;
   pipe_ctl_type ctl;
   mat_row_type  rows [MAT_ROWS];
   logic signed [SUM_W-1:0] sums [MAT_ROWS];
   coord_type    res_in [MAT_ROWS];
   coord_type    res_ff [MAT_ROWS];
   logic         sat_in, sat_ff;

   // Stage ready chain; a stage takes a word when empty or draining
   assign rdy3       = !v3_ff || !rsp_stall;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_stall  = !rdy1;
   assign req_accept = req_valid && rdy1;

   assign ctl.adv1 = rdy1;
   assign ctl.adv2 = rdy2;

   // Matrix entry write
   always_comb begin
      wr.we    = req_accept && (req_mode == MODE_LOAD) && (req_row_index != ROW_IGNORE);
      wr.row   = req_row_index;
      wr.col   = req_col_index;
      wr.value = req_entry_value;
   end

   apt_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
      .clock (clock),
      .reset (reset),
      .wr    (wr),
      .rows  (rows)
   );

   for (genvar r = 0; r < MAT_ROWS; r++) begin : g_row
      apt_row #(.FRAC_BITS(FRAC_BITS)) u_row (
         .clock (clock),
         .ctl   (ctl),
         .row   (rows[r]),
         .x     (req_in_x),
         .y     (req_in_y),
         .z     (req_in_z),
         .sum   (sums[r])
      );
   end

   // Advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid && (req_mode == MODE_POINT);
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   // Carry the last-point marker
   always_ff @(posedge clock) begin
      if (rdy1) last1_ff <= req_last_point;
      if (rdy2) last2_ff <= last1_ff;
      if (rdy3) last3_ff <= last2_ff;
   end

   // Clamp each coordinate to 32 bits and flag any clamp
   always_comb begin
      sat_in = 1'b0;
      for (int r = 0; r < MAT_ROWS; r++) begin
         if (sums[r] > SUM_W'(COORD_MAX)) begin
            res_in[r] = COORD_MAX;
            sat_in    = 1'b1;
         end else if (sums[r] < SUM_W'(COORD_MIN)) begin
            res_in[r] = COORD_MIN;
            sat_in    = 1'b1;
         end else begin
            res_in[r] = coord_type'(sums[r][COORD_W-1:0]);
         end
      end
   end

   // Stage 3: output register
   always_ff @(posedge clock) begin
      if (rdy3) begin
         res_ff <= res_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_valid     = v3_ff;
   assign rsp_out_x     = res_ff[0];
   assign rsp_out_y     = res_ff[1];
   assign rsp_out_z     = res_ff[2];
   assign rsp_out_last  = last3_ff;
   assign rsp_saturated = sat_ff;

   `AST_IMPLY(a_stall_only_full, clock, reset, req_stall, v1_ff && v2_ff && v3_ff && rsp_stall)
   `AST_NEXT(a_mid_holds, clock, reset, v2_ff && !rdy2, v2_ff)
   `AST_NEXT(a_point_enters, clock, reset, req_accept && (req_mode == MODE_POINT), v1_ff)

endmodule

@@ rtl/apt_matrix.sv @@
// ----------------------------------------------------------------------------
// apt_matrix
// 3x4 affine matrix store; resets to identity, written one entry per word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module apt_matrix import apt_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  mat_wr_type  wr,
   output mat_row_type rows [MAT_ROWS]
);

   localparam coord_type ONE_VAL = COORD_W'(1) << FRAC_BITS;

   mat_row_type mat_ff [MAT_ROWS];

   // Load identity on reset, else take the addressed entry
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < MAT_ROWS; r++) begin
            for (int c = 0; c < MAT_COLS; c++) begin
               mat_ff[r][c] <= (r == c) ? ONE_VAL : '0;
            end
         end
      end else if (wr.we) begin
         mat_ff[wr.row][wr.col] <= wr.value;
      end
   end

   assign rows = mat_ff;

   `AST_NEXT(a_write_lands, clock, reset, wr.we, mat_ff[$past(wr.row)][$past(wr.col)] == $past(wr.value))
   `AST_IMPLY(a_row_in_range, clock, reset, wr.we, wr.row != ROW_IGNORE)

endmodule

@@ rtl/apt_row.sv @@
// ----------------------------------------------------------------------------
// apt_row
// One matrix row dotted with (x, y, z, 1): registered products, then rounded
// products summed with the translation term.
// ----------------------------------------------------------------------------
module apt_row import apt_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                    clock,
   input  pipe_ctl_type            ctl,
   input  mat_row_type             row,
   input  coord_type               x,
   input  coord_type               y,
   input  coord_type               z,
   output logic signed [SUM_W-1:0] sum
);

   localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

   logic signed [PROD_W-1:0] px_ff, py_ff, pz_ff;
   coord_type                tr_ff;
   logic signed [PROD_W-1:0] rx, ry, rz;
   logic signed [SUM_W-1:0]  sum_in, sum_ff;

   // Stage 1: multiply, hold translation alongside
   always_ff @(posedge clock) begin
      if (ctl.adv1) begin
         px_ff <= PROD_W'(coord_type'(row[0])) * PROD_W'(x);
         py_ff <= PROD_W'(coord_type'(row[1])) * PROD_W'(y);
         pz_ff <= PROD_W'(coord_type'(row[2])) * PROD_W'(z);
         tr_ff <= coord_type'(row[COL_TRANS]);
      end
   end

   // Round half up back to the fixed-point format and add
   always_comb begin
      rx     = (px_ff + HALF) >>> FRAC_BITS;
      ry     = (py_ff + HALF) >>> FRAC_BITS;
      rz     = (pz_ff + HALF) >>> FRAC_BITS;
      sum_in = SUM_W'(rx) + SUM_W'(ry) + SUM_W'(rz) + SUM_W'(tr_ff);
   end

   // Stage 2: hold the exact sum
   always_ff @(posedge clock) begin
      if (ctl.adv2) begin
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

@@ tb/tb_affine_point_transform.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_affine_point_transform
// Self-checking bench for the 3x4 affine point transform. A short directed
// run hits the rounding of half an LSB, clamping at both ends, translation
// and dropped loads to row three. Random batches follow: matrix updates, then
// streams of points closed by a last marker, with a little noise mixed in.
// Each accepted word updates a local copy of the matrix or predicts a
// transformed point. Result words are checked in order against those
// predictions, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_affine_point_transform;
   import apt_pkg::*;

   localparam int FRAC_BITS      = 16;
   localparam int WORD_TARGET    = 1050;
   localparam int DRAIN_CYCLES   = 10;
   localparam int WATCHDOG_LIMIT = 5000;

   // One word on the input channel
   typedef struct {
      logic             mode;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      coord_type        value;
      coord_type        x;
      coord_type        y;
      coord_type        z;
      logic             last;
   } stream_word_type;

   // One transformed point on the result channel
   typedef struct {
      coord_type x;
      coord_type y;
      coord_type z;
      logic      last;
      logic      sat;
   } transformed_point_type;

   logic             clock;
   logic             reset           = 1'b1;
   logic             req_valid       = 1'b0;
   logic             req_stall;
   logic             req_mode        = MODE_LOAD;
   logic [IDX_W-1:0] req_row_index   = '0;
   logic [IDX_W-1:0] req_col_index   = '0;
   coord_type        req_in_x        = '0;
   coord_type        req_in_y        = '0;
   coord_type        req_in_z        = '0;
   coord_type        req_entry_value = '0;
   logic             req_last_point  = 1'b0;
   logic             rsp_valid;
   logic             rsp_stall       = 1'b0;
   coord_type        rsp_out_x;
   coord_type        rsp_out_y;
   coord_type        rsp_out_z;
   logic             rsp_out_last;
   logic             rsp_saturated;

   stream_word_type       word_queue [$];
   transformed_point_type awaited_points [$];
   coord_type             coeff [0:MAT_ROWS-1][0:MAT_COLS-1];

   int   words_total     = 0;
   int   words_accepted  = 0;
   int   stuck_cycles    = 0;
   int   fail_count      = 0;
   logic word_taken      = 1'b0;
   int   send_gap        = 0;
   int   send_calm       = 0;
   int   stall_left      = 0;
   int   recv_calm       = 0;

   affine_point_transform #(.FRAC_BITS(FRAC_BITS)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_row_index   (req_row_index),
      .req_col_index   (req_col_index),
      .req_entry_value (req_entry_value),
      .req_in_x        (req_in_x),
      .req_in_y        (req_in_y),
      .req_in_z        (req_in_z),
      .req_last_point  (req_last_point),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_out_z       (rsp_out_z),
      .rsp_out_last    (rsp_out_last),
      .rsp_saturated   (rsp_saturated)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Product rounded half towards plus infinity back to the fixed-point format
   function automatic longint rounded_product(coord_type a, coord_type b);
      longint p;
      p = longint'(a) * longint'(b);
      return (p + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
   endfunction

   // Each row dotted with (x, y, z, 1), clamped to 32 bits
   function automatic transformed_point_type transform_point(coord_type px, coord_type py,
                                                             coord_type pz, logic last);
      transformed_point_type res;
      coord_type             axis [0:MAT_ROWS-1];
      longint                acc;
      int                    r;
      res.sat  = 1'b0;
      res.last = last;
      for (r = 0; r < MAT_ROWS; r++) begin
         acc = rounded_product(coeff[r][0], px) + rounded_product(coeff[r][1], py)
             + rounded_product(coeff[r][2], pz) + longint'(coeff[r][COL_TRANS]);
         if (acc > longint'(COORD_MAX)) begin
            acc     = longint'(COORD_MAX);
            res.sat = 1'b1;
         end else if (acc < longint'(COORD_MIN)) begin
            acc     = longint'(COORD_MIN);
            res.sat = 1'b1;
         end
         axis[r] = coord_type'(acc);
      end
      res.x = axis[0];
      res.y = axis[1];
      res.z = axis[2];
      return res;
   endfunction

   // Apply one accepted word to the local matrix, or predict its point
   function automatic void absorb_word(stream_word_type w);
      if (w.mode == MODE_LOAD) begin
         if (w.row != ROW_IGNORE) coeff[w.row][w.col] = w.value;
      end else begin
         awaited_points.push_back(transform_point(w.x, w.y, w.z, w.last));
      end
   endfunction

   task automatic check_field(string name, logic [COORD_W-1:0] got,
                              logic [COORD_W-1:0] want);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // Idle length: mostly none or short, now and then long, with calm runs
   task automatic next_gap(inout int calm, output int gap);
      int roll;
      roll = $urandom_range(0, 99);
      if (calm > 0) begin
         calm--;
         gap = 0;
      end else if (roll < 3) begin
         calm = $urandom_range(20, 80);
         gap  = 0;
      end else if (roll < 55) begin
         gap = 0;
      end else if (roll < 90) begin
         gap = $urandom_range(1, 3);
      end else begin
         gap = $urandom_range(8, 30);
      end
   endtask

   function automatic coord_type extreme_value();
      case ($urandom_range(0, 4))
         0: return COORD_MAX;
         1: return COORD_MIN;
         2: return 32'sh0001_0000;
         3: return -32'sh0001_0000;
         default: return '0;
      endcase
   endfunction

   // Matrix entries: mostly gains within +/-2.0, some wide, some extreme
   function automatic coord_type random_entry();
      coord_type v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: v = coord_type'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
         5, 6:          v = coord_type'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
         7:             v = coord_type'($urandom);
         8:             v = extreme_value();
         default:       v = '0;
      endcase
      return v;
   endfunction

   // Point coordinates: mostly within +/-256.0, some full range or extreme
   function automatic coord_type random_coord();
      coord_type v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: v = coord_type'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
         6, 7:             v = coord_type'($urandom);
         8:                v = extreme_value();
         default:          v = coord_type'($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
      endcase
      return v;
   endfunction

   function automatic logic [IDX_W-1:0] random_row();
      if ($urandom_range(0, 9) == 0) return ROW_IGNORE;
      return IDX_W'($urandom_range(0, MAT_ROWS - 1));
   endfunction

   // Point fields of a load word are don't-care: fill them at random
   task automatic queue_load(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col, coord_type v);
      stream_word_type w;
      w.mode  = MODE_LOAD;
      w.row   = row;
      w.col   = col;
      w.value = v;
      w.x     = coord_type'($urandom);
      w.y     = coord_type'($urandom);
      w.z     = coord_type'($urandom);
      w.last  = 1'($urandom_range(0, 1));
      word_queue.push_back(w);
   endtask

   task automatic queue_point(coord_type x, coord_type y, coord_type z, logic last);
      stream_word_type w;
      w.mode  = MODE_POINT;
      w.row   = IDX_W'($urandom_range(0, 3));
      w.col   = IDX_W'($urandom_range(0, 3));
      w.value = coord_type'($urandom);
      w.x     = x;
      w.y     = y;
      w.z     = z;
      w.last  = last;
      word_queue.push_back(w);
   endtask

   // Stimulus, reset and end of run
   initial begin
      int r;
      int c;
      int i;
      int n;
      for (r = 0; r < MAT_ROWS; r++) begin
         for (c = 0; c < MAT_COLS; c++) begin
            coeff[r][c] = (r == c) ? (32'sd1 <<< FRAC_BITS) : '0;
         end
      end

      // Identity passes the extremes straight through
      queue_point(COORD_MAX, COORD_MIN, '0, 1'b1);
      queue_point(-32'sd1, 32'sd1, 32'sh0001_0000, 1'b0);
      // Smallest gain on X: half an LSB rounds up, just under half rounds down
      queue_load(2'd0, 2'd0, 32'sd1);
      queue_point(32'sh0000_8000, 32'sh0000_7FFF, -32'sd1, 1'b0);
      queue_point(-32'sh0000_8000, '0, '0, 1'b1);
      queue_point(-32'sh0000_8001, COORD_MAX, COORD_MIN, 1'b0);
      queue_point(COORD_MAX, '0, '0, 1'b0);
      // Translation pushes X over the top
      queue_load(2'd0, 2'd0, 32'sh0001_0000);
      queue_load(2'd0, COL_TRANS, COORD_MAX);
      queue_point(32'sh0001_0000, '0, '0, 1'b1);
      // Most negative gain and offset drive Y below the bottom
      queue_load(2'd1, 2'd1, COORD_MIN);
      queue_load(2'd1, COL_TRANS, COORD_MIN);
      queue_point('0, COORD_MAX, '0, 1'b1);
      // Loads to row three must leave the matrix alone
      queue_load(ROW_IGNORE, 2'd0, COORD_MAX);
      queue_load(ROW_IGNORE, COL_TRANS, COORD_MIN);
      queue_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 1'b0);
      // Z row at the extremes
      queue_load(2'd2, 2'd0, COORD_MIN);
      queue_load(2'd2, 2'd1, -32'sd1);
      queue_load(2'd2, 2'd2, COORD_MAX);
      queue_load(2'd2, COL_TRANS, 32'sh0000_8000);
      queue_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
      queue_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);

      // Random batches: update the matrix, then a run of points, the last one usually marked last
      while (word_queue.size() < WORD_TARGET) begin
         if ($urandom_range(0, 3) == 0) begin
            for (r = 0; r < MAT_ROWS; r++) begin
               for (c = 0; c < MAT_COLS; c++) begin
                  queue_load(IDX_W'(r), IDX_W'(c), random_entry());
               end
            end
         end else begin
            n = $urandom_range(0, 3);
            repeat (n) queue_load(random_row(), IDX_W'($urandom_range(0, 3)), random_entry());
         end
         n = $urandom_range(1, 30);
         for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 39) == 0) begin
               queue_load(random_row(), IDX_W'($urandom_range(0, 3)), random_entry());
            end
            queue_point(random_coord(), random_coord(), random_coord(),
                        (i == n - 1) ^ ($urandom_range(0, 19) == 0));
         end
      end
      words_total = word_queue.size();

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (words_accepted < words_total) @(posedge clock);
      while (awaited_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Input driver: hold a stalled word, otherwise idle or advance
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !word_taken) begin
         req_valid <= 1'b1;
      end else if (send_gap > 0) begin
         send_gap--;
         req_valid <= 1'b0;
      end else if (word_queue.size() != 0) begin
         stream_word_type w;
         w = word_queue.pop_front();
         req_mode        <= w.mode;
         req_row_index   <= w.row;
         req_col_index   <= w.col;
         req_entry_value <= w.value;
         req_in_x        <= w.x;
         req_in_y        <= w.y;
         req_in_z        <= w.z;
         req_last_point  <= w.last;
         req_valid       <= 1'b1;
         next_gap(send_calm, send_gap);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Result side back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         next_gap(recv_calm, stall_left);
      end
   end

   // Monitor: predict on accepted input words, check accepted result words
   always @(posedge clock) begin
      logic in_fire;
      logic out_fire;
      transformed_point_type want;
      in_fire  = !reset && req_valid && !req_stall;
      out_fire = !reset && rsp_valid && !rsp_stall;
      word_taken <= in_fire;

      if (out_fire) begin
         if (awaited_points.size() == 0) begin
            $display("%0t: unexpected result word x=%h y=%h z=%h", $time,
                     rsp_out_x, rsp_out_y, rsp_out_z);
            fail_count++;
         end else begin
            want = awaited_points.pop_front();
            check_field("out_x", rsp_out_x, want.x);
            check_field("out_y", rsp_out_y, want.y);
            check_field("out_z", rsp_out_z, want.z);
            check_field("out_last", 32'(rsp_out_last), 32'(want.last));
            check_field("saturated", 32'(rsp_saturated), 32'(want.sat));
         end
      end

      if (in_fire) begin
         absorb_word('{req_mode, req_row_index, req_col_index, req_entry_value,
                       req_in_x, req_in_y, req_in_z, req_last_point});
         words_accepted++;
      end

      if (reset || in_fire || out_fire) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
   end

   // Watchdog: end the run if nothing moves for too long
   initial begin
      wait (stuck_cycles >= WATCHDOG_LIMIT);
      $display("%0t: no word accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
   end

endmodule
